// ===== rtl/pmsu_pkg.sv =====
// ============================================================================
// pmsu_pkg: shared types and constants of the Potts site update block
// Command codes, register indexes and field widths.
// ============================================================================
package pmsu_pkg;

    localparam int SIZE_X_DEF    = 16;
    localparam int SIZE_Y_DEF    = 16;
    localparam int SIZE_Z_DEF    = 16;
    localparam int SPIN_BITS_DEF = 8;

    localparam int POS_W    = 4;
    localparam int SPIN_W   = 8;
    localparam int FRAC_W   = 16;
    localparam int ENERGY_W = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int NEIGHBOURS  = 12;
    localparam int TABLE_DEPTH = 12;
    localparam logic [ENERGY_W-1:0] MASK_ENERGY_LIMIT = 4'd6;

    typedef enum logic [1:0] {
        CMD_WRITE_SPIN = 2'd0,
        CMD_FLIP       = 2'd1,
        CMD_READ       = 2'd2,
        CMD_WRITE_BOLTZ = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_SPIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_ZERO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_EN    = 2'd2;

endpackage

// ===== rtl/potts_metropolis_site_update.sv =====
// ============================================================================
// potts_metropolis_site_update: Metropolis spin flip on a periodic 3D lattice
// Lattice spins and mask bits live in two synchronous memories; a sequencer
// reads, decides and writes back one command word at a time.
// ============================================================================
// Usage:
// Input words arrive on i_valid / o_stall with one port per field. A word is
// taken when i_valid is high and o_stall is low. Result words leave on
// o_valid / i_stall and are taken when o_valid is high and i_stall is low.
// Every command gives exactly one result word.
// A table write passes the site and finish states; write spin and read site
// pass site, site wait and finish. A flip attempt reads the site and then its
// twelve neighbours through the spin memory's single read port, one a cycle,
// then passes the decide, lookup and write states; when the spin changes with
// masking on, it next clears the twelve neighbour masks through the mask
// memory's write port before the finish state shows its result. The next
// word can be taken in the cycle after the result is loaded.
// The block takes one word at a time: o_stall is high from acceptance until
// the result has been loaded into the output register. A finished result
// waits in that register while i_stall is high, and the next word may be
// accepted meanwhile, its result waiting until the register is free.
// Reset (synchronous, active low) returns registers to their reset values.
// The mask memory is then cleared by a sweep over all SIZE_X*SIZE_Y*SIZE_Z
// sites (4096 at the default size) during which no word is accepted;
// configuration writes are taken throughout. The spin memory is not cleared.
// ============================================================================
module potts_metropolis_site_update #(
    parameter int SIZE_X    = pmsu_pkg::SIZE_X_DEF,
    parameter int SIZE_Y    = pmsu_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z    = pmsu_pkg::SIZE_Z_DEF,
    parameter int SPIN_BITS = pmsu_pkg::SPIN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmsu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmsu_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [pmsu_pkg::POS_W-1:0]    i_pos_x,
    input  logic [pmsu_pkg::POS_W-1:0]    i_pos_y,
    input  logic [pmsu_pkg::POS_W-1:0]    i_pos_z,
    input  logic [pmsu_pkg::SPIN_W-1:0]   i_spin_value,
    input  logic [pmsu_pkg::FRAC_W-1:0]   i_uniform_draw,
    input  logic [pmsu_pkg::POS_W-1:0]    i_delta_index,
    input  logic [pmsu_pkg::FRAC_W-1:0]   i_factor_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pmsu_pkg::SPIN_W-1:0]   o_site_spin,
    output logic                          o_changed,
    output logic [pmsu_pkg::ENERGY_W-1:0] o_energy_before,
    output logic [pmsu_pkg::ENERGY_W-1:0] o_energy_after,
    output logic                          o_mask_bit
);

    localparam int XW = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int YW = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
    localparam int ZW = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int SITES = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW = $clog2(SITES);
    localparam int NW = 4;
    localparam int EW = pmsu_pkg::ENERGY_W;
    localparam int SB = SPIN_BITS;
    localparam logic [EW-1:0] MASK_E = pmsu_pkg::MASK_ENERGY_LIMIT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SITE, S_SITE_WAIT, S_NREAD, S_DECIDE, S_LOOKUP,
        S_WRITE, S_MCLEAR, S_FINISH
    } t_state;

    // ---------------- configuration registers ----------------
    logic [pmsu_pkg::CFG_W-1:0] r_spin_count;
    logic r_temp_zero, r_mask_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_count <= pmsu_pkg::CFG_W'(2);
            r_temp_zero  <= 1'b0;
            r_mask_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pmsu_pkg::REG_SPIN_COUNT: r_spin_count <= i_cfg_data;
                pmsu_pkg::REG_TEMP_ZERO:  r_temp_zero  <= i_cfg_data[0];
                pmsu_pkg::REG_MASK_EN:    r_mask_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- memories ----------------
    logic [SB-1:0] spin_mem [SITES];
    logic          mask_mem [SITES];
    logic [pmsu_pkg::FRAC_W-1:0] r_table [pmsu_pkg::TABLE_DEPTH];

    logic          spin_we, mask_we, mask_wd;
    logic [AW-1:0] spin_ra, spin_wa, mask_ra, mask_wa;
    logic [SB-1:0] spin_wd, r_spin_rd;
    logic          r_mask_rd;

    always_ff @(posedge i_clk) begin
        if (spin_we) spin_mem[spin_wa] <= spin_wd;
        r_spin_rd <= spin_mem[spin_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mask_we) mask_mem[mask_wa] <= mask_wd;
        r_mask_rd <= mask_mem[mask_ra];
    end

    // ---------------- item registers ----------------
    t_state r_state;
    logic [1:0]    r_cmd;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [SB-1:0] r_cand, r_old;
    logic [pmsu_pkg::FRAC_W-1:0] r_draw, r_factor;
    logic [pmsu_pkg::POS_W-1:0]  r_didx;
    logic [NW-1:0] r_n;
    logic [EW-1:0] r_e0, r_e1;
    logic          r_accept, r_changed, r_mbit;
    logic [AW-1:0] r_clr;
    logic [pmsu_pkg::FRAC_W-1:0] r_boltz;

    logic [AW-1:0] site_a, nb_a;

    pmsu_addr #(
        .SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)
    ) u_addr (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .i_n     (r_n),
        .o_site  (site_a),
        .o_neigh (nb_a)
    );

    // Input coordinates wrap modulo the lattice size through a loop of compare-
    // subtract steps; one step suffices when the 4-bit field is under twice the size.
    function automatic logic [7:0] wrap_c(input logic [3:0] c, input int size);
        logic [8:0] v;
        v = {5'd0, c};
        for (int k = 0; k < 4; k++) begin
            if (v >= 9'(size)) v = v - 9'(size);
        end
        return v[7:0];
    endfunction

    logic [SB-1:0] in_spin, in_cand;
    logic [7:0]    wx, wy, wz;
    logic          out_free, accept_in;

    always_comb begin
        logic [15:0] sv;
        sv = {8'd0, i_spin_value};
        in_spin = sv[SB-1:0];
        if (16'(in_spin) > 16'(r_spin_count)) in_cand = SB'(r_spin_count);
        else in_cand = in_spin;
        wx = wrap_c(i_pos_x, SIZE_X);
        wy = wrap_c(i_pos_y, SIZE_Y);
        wz = wrap_c(i_pos_z, SIZE_Z);
    end

    // Only the stored value is compared below SPIN_BITS; the clamped value
    // uses the full comparison against spin_count above.
    assign out_free  = !o_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign accept_in = i_valid && !o_stall;

    logic [EW:0] de;
    logic [3:0]  tidx;
    assign de   = {1'b0, r_e1} - {1'b0, r_e0};
    assign tidx = 4'(de - 1'b1);

    always_comb begin
        spin_ra = site_a;
        mask_ra = site_a;
        if (r_state == S_NREAD || r_state == S_SITE_WAIT) spin_ra = nb_a;
        spin_we = 1'b0;
        spin_wa = site_a;
        spin_wd = r_cand;
        mask_we = 1'b0;
        mask_wa = site_a;
        mask_wd = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mask_we = 1'b1;
                mask_wa = r_clr;
            end
            S_SITE: begin
                if (r_cmd == pmsu_pkg::CMD_WRITE_SPIN) begin
                    spin_we = 1'b1;
                    spin_wd = r_cand;
                end
            end
            S_WRITE: begin
                if (r_accept && r_cand != r_old) spin_we = 1'b1;
                if (r_mask_en && r_e0 < MASK_E) begin
                    mask_we = 1'b1;
                    mask_wd = 1'b1;
                end
            end
            S_MCLEAR: begin
                mask_we = 1'b1;
                mask_wa = nb_a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < pmsu_pkg::TABLE_DEPTH; i++) r_table[i] <= '0;
        end else begin
            // A taken word leaves the register unless a new one loads now.
            if (o_valid && !i_stall && r_state != S_FINISH) o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(SITES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept_in) begin
                        r_cmd     <= i_cmd;
                        r_x       <= wx[XW-1:0];
                        r_y       <= wy[YW-1:0];
                        r_z       <= wz[ZW-1:0];
                        r_cand    <= (i_cmd == pmsu_pkg::CMD_FLIP) ? in_cand : in_spin;
                        r_draw    <= i_uniform_draw;
                        r_didx    <= i_delta_index;
                        r_factor  <= i_factor_value;
                        r_n       <= '0;
                        r_e0      <= '0;
                        r_e1      <= '0;
                        r_changed <= 1'b0;
                        r_state   <= S_SITE;
                    end
                end
                S_SITE: begin
                    // Site read issued this cycle (write spin writes too).
                    if (r_cmd == pmsu_pkg::CMD_WRITE_BOLTZ) begin
                        if (r_didx >= 4'd1 && r_didx <= 4'(pmsu_pkg::TABLE_DEPTH))
                            r_table[r_didx - 4'd1] <= r_factor;
                        r_old  <= '0;
                        r_mbit <= 1'b0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SITE_WAIT;
                    end
                end
                S_SITE_WAIT: begin
                    r_old  <= (r_cmd == pmsu_pkg::CMD_WRITE_SPIN) ? r_cand : r_spin_rd;
                    r_mbit <= r_mask_rd;
                    if (r_cmd == pmsu_pkg::CMD_FLIP) begin
                        r_n       <= r_n + 1'b1;
                        r_state   <= S_NREAD;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_NREAD: begin
                    // Neighbour r_n-1 data arrives while r_n is addressed.
                    if (r_spin_rd != r_old)  r_e0 <= r_e0 + 1'b1;
                    if (r_spin_rd != r_cand) r_e1 <= r_e1 + 1'b1;
                    if (r_n == NW'(pmsu_pkg::NEIGHBOURS)) begin
                        r_state <= S_DECIDE;
                        r_n     <= '0;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_boltz <= r_table[(tidx < 4'(pmsu_pkg::TABLE_DEPTH)) ? tidx : 4'd0];
                    r_state <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    if (r_e1 > r_e0)
                        r_accept <= !r_temp_zero && (r_draw <= r_boltz);
                    else
                        r_accept <= 1'b1;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_accept && r_cand != r_old) begin
                        r_changed <= 1'b1;
                        r_old     <= r_cand;
                    end
                    if (r_mask_en && r_e0 < MASK_E) r_mbit <= 1'b1;
                    if (r_mask_en && r_accept && r_cand != r_old) r_state <= S_MCLEAR;
                    else r_state <= S_FINISH;
                end
                S_MCLEAR: begin
                    // Neighbours are never the site itself (sizes of 5 or more).
                    if (r_n == NW'(pmsu_pkg::NEIGHBOURS - 1)) r_state <= S_FINISH;
                    r_n <= r_n + 1'b1;
                end
                S_FINISH: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        o_site_spin <= pmsu_pkg::SPIN_W'(r_old);
                        o_changed <= r_changed;
                        o_energy_before <= r_e0;
                        o_energy_after  <= r_e1;
                        o_mask_bit <= r_mbit;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pmsu_addr.sv =====
// ============================================================================
// pmsu_addr: lattice address generator
// Forms the site address and the address of neighbour n with periodic wrap.
// ============================================================================
module pmsu_addr #(
    parameter int SIZE_X = pmsu_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = pmsu_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = pmsu_pkg::SIZE_Z_DEF,
    localparam int XW = (SIZE_X > 1) ? $clog2(SIZE_X) : 1,
    localparam int YW = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1,
    localparam int ZW = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1,
    localparam int AW = $clog2(SIZE_X * SIZE_Y * SIZE_Z)
) (
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    input  logic [ZW-1:0] i_z,
    input  logic [3:0]    i_n,
    output logic [AW-1:0] o_site,
    output logic [AW-1:0] o_neigh
);

    function automatic logic [8:0] step_c(input logic [8:0] c, input logic [1:0] k,
                                          input int size);
        logic [9:0] v;
        case (k)
            2'd0: v = {1'b0, c} + 10'(size) - 10'd2;
            2'd1: v = {1'b0, c} + 10'(size) - 10'd1;
            2'd2: v = {1'b0, c} + 10'd1;
            default: v = {1'b0, c} + 10'd2;
        endcase
        if (v >= 10'(size)) v = v - 10'(size);
        return v[8:0];
    endfunction

    function automatic logic [AW-1:0] addr(input logic [8:0] x, input logic [8:0] y,
                                           input logic [8:0] z);
        logic [31:0] a;
        a = (32'(x) * 32'(SIZE_Y) + 32'(y)) * 32'(SIZE_Z) + 32'(z);
        return a[AW-1:0];
    endfunction

    logic [8:0] x9, y9, z9, nx, ny, nz;
    logic [3:0] ni;

    always_comb begin
        x9 = 9'(i_x);
        y9 = 9'(i_y);
        z9 = 9'(i_z);
        // Neighbour index 12 wraps onto 0; its address is not used.
        ni = (i_n >= 4'd12) ? 4'd0 : i_n;
        nx = x9;
        ny = y9;
        nz = z9;
        case (ni[3:2])
            2'd0:    nx = step_c(x9, ni[1:0], SIZE_X);
            2'd1:    ny = step_c(y9, ni[1:0], SIZE_Y);
            default: nz = step_c(z9, ni[1:0], SIZE_Z);
        endcase
        o_site  = addr(x9, y9, z9);
        o_neigh = addr(nx, ny, nz);
    end

endmodule

// ===== rtl/pmsu_checker.sv =====
// ============================================================================
// pmsu_checker: port-level checks of the Potts site update block
// Watches the handshakes and the result fields.
// ============================================================================
module pmsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_changed,
    input logic [3:0] o_energy_before,
    input logic [3:0] o_energy_after,
    input logic [7:0] o_site_spin
);

    // A held result word does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_site_spin))
        else $error("result word changed while stalled");

    // Energies never exceed the neighbour count.
    a_energy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_energy_before <= 4'd12 && o_energy_after <= 4'd12)
        else $error("energy out of range");

    // The flag and energies of a held result word stay put as well.
    a_fields_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_changed) && $stable(o_energy_before) &&
                               $stable(o_energy_after))
        else $error("result fields changed while stalled");

    // A word accepted is not followed by another accept in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted too soon");

endmodule

bind potts_metropolis_site_update pmsu_checker u_pmsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_changed       (o_changed),
    .o_energy_before (o_energy_before),
    .o_energy_after  (o_energy_after),
    .o_site_spin     (o_site_spin)
);

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for the Potts Metropolis site update block
// Keeps its own copy of the lattice, the mask bits, the Boltzmann table and
// the registers. Each accepted command word is predicted and the result words
// are compared in order, while both sides idle and stall at random.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ITEMS   = 50;

    // One result word as the block presents it.
    typedef struct {
        logic [pmsu_pkg::SPIN_W-1:0]   site_spin;
        logic                          changed;
        logic [pmsu_pkg::ENERGY_W-1:0] energy_before;
        logic [pmsu_pkg::ENERGY_W-1:0] energy_after;
        logic                          mask_bit;
    } t_site_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [pmsu_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pmsu_pkg::CFG_W-1:0]      i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [1:0]                      i_cmd = pmsu_pkg::CMD_READ;
    logic [pmsu_pkg::POS_W-1:0]      i_pos_x = '0;
    logic [pmsu_pkg::POS_W-1:0]      i_pos_y = '0;
    logic [pmsu_pkg::POS_W-1:0]      i_pos_z = '0;
    logic [pmsu_pkg::SPIN_W-1:0]     i_spin_value = '0;
    logic [pmsu_pkg::FRAC_W-1:0]     i_uniform_draw = '0;
    logic [pmsu_pkg::POS_W-1:0]      i_delta_index = '0;
    logic [pmsu_pkg::FRAC_W-1:0]     i_factor_value = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [pmsu_pkg::SPIN_W-1:0]     o_site_spin;
    logic                            o_changed;
    logic [pmsu_pkg::ENERGY_W-1:0]   o_energy_before;
    logic [pmsu_pkg::ENERGY_W-1:0]   o_energy_after;
    logic                            o_mask_bit;

    potts_metropolis_site_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_cmd(i_cmd),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_spin_value(i_spin_value), .i_uniform_draw(i_uniform_draw),
        .i_delta_index(i_delta_index), .i_factor_value(i_factor_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_site_spin(o_site_spin),
        .o_changed(o_changed), .o_energy_before(o_energy_before),
        .o_energy_after(o_energy_after), .o_mask_bit(o_mask_bit)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's state. Addresses are {x, y, z}, which is the
    // row-major order of the lattice at its 16x16x16 size.
    logic [pmsu_pkg::SPIN_W-1:0] lattice_spin [0:4095];
    logic                        lattice_mask [0:4095];
    logic [pmsu_pkg::FRAC_W-1:0] boltz_factor [0:pmsu_pkg::TABLE_DEPTH-1];
    logic [pmsu_pkg::CFG_W-1:0]  cfg_spin_count;
    logic                        cfg_temp_zero;
    logic                        cfg_mask_en;

    t_site_result pending_results[$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  no_idling = 1'b0;   // when set, neither side idles or stalls
    int  stall_left = 0;

    // Address of neighbour n: offsets -2, -1, +1, +2 along x, then y, then z.
    // Periodic wrap comes for free from 4-bit arithmetic.
    function automatic logic [11:0] neighbour_addr(logic [3:0] x, logic [3:0] y,
                                                   logic [3:0] z, int n);
        logic [3:0] offset;
        case (n % 4)
            0: offset = 4'hE;
            1: offset = 4'hF;
            2: offset = 4'h1;
            default: offset = 4'h2;
        endcase
        case (n / 4)
            0: return {x + offset, y, z};
            1: return {x, y + offset, z};
            default: return {x, y, z + offset};
        endcase
    endfunction

    function automatic logic [pmsu_pkg::ENERGY_W-1:0] count_mismatches(
            logic [3:0] x, logic [3:0] y, logic [3:0] z,
            logic [pmsu_pkg::SPIN_W-1:0] spin);
        logic [pmsu_pkg::ENERGY_W-1:0] e;
        e = '0;
        for (int n = 0; n < pmsu_pkg::NEIGHBOURS; n++)
            if (lattice_spin[neighbour_addr(x, y, z, n)] != spin)
                e++;
        return e;
    endfunction

    // Applies one command word to the shadow state and returns its result.
    function automatic t_site_result predict_site_update(pmsu_pkg::t_cmd cmd,
            logic [3:0] x, logic [3:0] y, logic [3:0] z,
            logic [pmsu_pkg::SPIN_W-1:0] spin, logic [pmsu_pkg::FRAC_W-1:0] draw,
            logic [3:0] didx, logic [pmsu_pkg::FRAC_W-1:0] factor);
        t_site_result r;
        logic [11:0] a;
        logic [pmsu_pkg::SPIN_W-1:0] old_spin, cand;
        logic [3:0] tidx;
        bit accept;
        r = '{default: '0};
        a = {x, y, z};
        case (cmd)
            pmsu_pkg::CMD_WRITE_SPIN: begin
                lattice_spin[a] = spin;
                r.site_spin = spin;
                r.mask_bit = lattice_mask[a];
            end
            pmsu_pkg::CMD_FLIP: begin
                old_spin = lattice_spin[a];
                cand = (spin > cfg_spin_count) ? cfg_spin_count : spin;
                r.energy_before = count_mismatches(x, y, z, old_spin);
                r.energy_after = count_mismatches(x, y, z, cand);
                accept = 1'b1;
                // Uphill moves pass only against the table entry for their size.
                if (r.energy_after > r.energy_before) begin
                    tidx = r.energy_after - r.energy_before - 4'd1;
                    if (cfg_temp_zero)
                        accept = 1'b0;
                    else if (draw > boltz_factor[tidx])
                        accept = 1'b0;
                end
                if (accept && cand != old_spin) begin
                    lattice_spin[a] = cand;
                    r.changed = 1'b1;
                end
                if (cfg_mask_en) begin
                    if (r.energy_before < pmsu_pkg::MASK_ENERGY_LIMIT)
                        lattice_mask[a] = 1'b1;
                    if (r.changed)
                        for (int n = 0; n < pmsu_pkg::NEIGHBOURS; n++)
                            lattice_mask[neighbour_addr(x, y, z, n)] = 1'b0;
                end
                r.site_spin = lattice_spin[a];
                r.mask_bit = lattice_mask[a];
            end
            pmsu_pkg::CMD_READ: begin
                r.site_spin = lattice_spin[a];
                r.mask_bit = lattice_mask[a];
            end
            default: begin
                if (didx >= 4'd1 && didx <= 4'(pmsu_pkg::TABLE_DEPTH))
                    boltz_factor[didx - 4'd1] = factor;
            end
        endcase
        return r;
    endfunction

    // Sends one command word and records its expected result on acceptance.
    task automatic send_word(pmsu_pkg::t_cmd cmd, logic [3:0] x, logic [3:0] y,
                             logic [3:0] z, logic [pmsu_pkg::SPIN_W-1:0] spin,
                             logic [pmsu_pkg::FRAC_W-1:0] draw, logic [3:0] didx,
                             logic [pmsu_pkg::FRAC_W-1:0] factor);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        i_cmd = cmd;
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        i_spin_value = spin;
        i_uniform_draw = draw;
        i_delta_index = didx;
        i_factor_value = factor;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_site_update(cmd, x, y, z, spin, draw,
                                                      didx, factor));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_spin(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                             logic [pmsu_pkg::SPIN_W-1:0] spin);
        send_word(pmsu_pkg::CMD_WRITE_SPIN, x, y, z, spin, 16'd0, 4'd0, 16'd0);
    endtask

    task automatic send_read(logic [3:0] x, logic [3:0] y, logic [3:0] z);
        send_word(pmsu_pkg::CMD_READ, x, y, z, 8'd0, 16'd0, 4'd0, 16'd0);
    endtask

    task automatic send_flip(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                             logic [pmsu_pkg::SPIN_W-1:0] spin,
                             logic [pmsu_pkg::FRAC_W-1:0] draw);
        send_word(pmsu_pkg::CMD_FLIP, x, y, z, spin, draw, 4'd0, 16'd0);
    endtask

    task automatic send_table(logic [3:0] didx, logic [pmsu_pkg::FRAC_W-1:0] factor);
        send_word(pmsu_pkg::CMD_WRITE_BOLTZ, 4'd0, 4'd0, 4'd0, 8'd0, 16'd0, didx, factor);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(logic [pmsu_pkg::CFG_IDX_W-1:0] index,
                                  logic [pmsu_pkg::CFG_W-1:0] value);
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (index)
            pmsu_pkg::REG_SPIN_COUNT: cfg_spin_count = value;
            pmsu_pkg::REG_TEMP_ZERO:  cfg_temp_zero = value[0];
            pmsu_pkg::REG_MASK_EN:    cfg_mask_en = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [pmsu_pkg::CFG_W-1:0] count, bit temp_zero,
                                  bit mask_en);
        write_register(pmsu_pkg::REG_SPIN_COUNT, count);
        write_register(pmsu_pkg::REG_TEMP_ZERO, {7'd0, temp_zero});
        write_register(pmsu_pkg::REG_MASK_EN, {7'd0, mask_en});
    endtask

    // Result side: random stalls after each taken word, none while no_idling is set.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Compare every taken result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_site_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = no_idling ? 0 : $urandom_range(0, 10);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Result word with nothing expected: spin %0d", o_site_spin);
            end else begin
                want = pending_results.pop_front();
                if (o_site_spin !== want.site_spin || o_changed !== want.changed ||
                    o_energy_before !== want.energy_before ||
                    o_energy_after !== want.energy_after ||
                    o_mask_bit !== want.mask_bit) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Result mismatch: expected spin %0d chg %0d e0 %0d",
                                  " e1 %0d mask %0d, got spin %0d chg %0d e0 %0d",
                                  " e1 %0d mask %0d"},
                                 want.site_spin, want.changed, want.energy_before,
                                 want.energy_after, want.mask_bit, o_site_spin,
                                 o_changed, o_energy_before, o_energy_after,
                                 o_mask_bit);
                end
            end
        end
    end

    // Watchdog: cycles with no word taken on either side. The limit covers the
    // mask clearing sweep after reset.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A coordinate from 14, 15, 0, 1, 2, 3: the written block around the origin.
    function automatic logic [3:0] near_origin();
        return 4'(32'd14 + $urandom_range(0, 5));
    endfunction

    // Every site within two steps of the origin cube gets a spin first, so
    // no flip at x, y, z in {0, 1} and no read in that block touches an
    // unwritten entry. Small spin values keep the energies spread out.
    task automatic test_lattice_fill();
        no_idling = 1'b1;
        for (int ix = 0; ix < 6; ix++)
            for (int iy = 0; iy < 6; iy++)
                for (int iz = 0; iz < 6; iz++)
                    send_spin(4'(14 + ix), 4'(14 + iy), 4'(14 + iz),
                              8'($urandom_range(0, 2)));
        no_idling = 1'b0;
    endtask

    // Table writes at both ends, plus indexes that must be ignored.
    task automatic test_table_writes();
        send_table(4'd1, 16'hFFFF);
        send_table(4'd12, 16'h0000);
        send_table(4'd0, 16'h1234);
        send_table(4'd15, 16'hABCD);
        send_table(4'd2, 16'h8000);
    endtask

    // Corner sites, widest spin value, saturation and an unchanged candidate.
    task automatic test_corner_sites();
        send_spin(4'hF, 4'hF, 4'hF, 8'hFF);
        send_read(4'hF, 4'hF, 4'hF);
        send_read(4'h0, 4'h0, 4'h0);
        send_flip(4'h0, 4'h0, 4'h0, 8'hFF, 16'hFFFF);
        send_flip(4'h0, 4'h0, 4'h0, lattice_spin[12'h000], 16'hFFFF);
    endtask

    // Isolated site: all neighbours 0, site 1; moving to 0 is downhill, then
    // the full uphill move to 2 meets a zero entry and passes only a zero draw.
    task automatic test_isolated_site();
        logic [11:0] a;
        for (int n = 0; n < pmsu_pkg::NEIGHBOURS; n++) begin
            a = neighbour_addr(4'h8, 4'h8, 4'h8, n);
            send_spin(a[11:8], a[7:4], a[3:0], 8'd0);
        end
        send_spin(4'h8, 4'h8, 4'h8, 8'd1);
        send_flip(4'h8, 4'h8, 4'h8, 8'd0, 16'hFFFF);
        send_flip(4'h8, 4'h8, 4'h8, 8'd2, 16'h0001);
        send_flip(4'h8, 4'h8, 4'h8, 8'd2, 16'h0000);
    endtask

    // Zero temperature rejects the uphill move that a zero draw would pass.
    task automatic test_zero_temperature();
        apply_settings(8'd2, 1'b1, 1'b1);
        send_flip(4'h8, 4'h8, 4'h8, 8'd0, 16'hFFFF);
        send_flip(4'h8, 4'h8, 4'h8, 8'd1, 16'h0000);
    endtask

    // Mostly flip attempts with random content, seasoned with the other commands.
    task automatic test_random(int count);
        int pick;
        logic [pmsu_pkg::SPIN_W-1:0] spin;
        logic [pmsu_pkg::FRAC_W-1:0] draw;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            no_idling = (i % 25) >= 18;
            spin = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: draw = 16'h0000;
                1: draw = 16'hFFFF;
                default: draw = 16'($urandom);
            endcase
            if (pick < 70)
                send_word(pmsu_pkg::CMD_FLIP, 4'($urandom_range(0, 1)),
                          4'($urandom_range(0, 1)), 4'($urandom_range(0, 1)), spin, draw,
                          4'($urandom), 16'($urandom));
            else if (pick < 80)
                send_word(pmsu_pkg::CMD_WRITE_SPIN, near_origin(), near_origin(),
                          near_origin(), spin, draw, 4'($urandom), 16'($urandom));
            else if (pick < 90)
                send_word(pmsu_pkg::CMD_READ, near_origin(), near_origin(), near_origin(),
                          spin, draw, 4'($urandom), 16'($urandom));
            else
                send_word(pmsu_pkg::CMD_WRITE_BOLTZ, 4'($urandom), 4'($urandom),
                          4'($urandom), spin, draw, 4'($urandom), 16'($urandom));
        end
        no_idling = 1'b0;
    endtask

    initial begin
        for (int a = 0; a < 4096; a++) begin
            lattice_spin[a] = '0;
            lattice_mask[a] = 1'b0;
        end
        for (int t = 0; t < pmsu_pkg::TABLE_DEPTH; t++)
            boltz_factor[t] = '0;
        cfg_spin_count = 8'd2;
        cfg_temp_zero = 1'b0;
        cfg_mask_en = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_lattice_fill();
        apply_settings(8'd3, 1'b0, 1'b1);
        test_table_writes();
        test_corner_sites();
        test_isolated_site();
        test_zero_temperature();
        test_random(RANDOM_ITEMS);
        apply_settings(8'd255, 1'b0, 1'b1);
        test_random(RANDOM_ITEMS);
        apply_settings(8'd1, 1'b0, 1'b0);
        test_random(RANDOM_ITEMS);
        apply_settings(8'd3, 1'b1, 1'b0);
        test_random(RANDOM_ITEMS);
        apply_settings(8'($urandom_range(1, 255)), 1'b0, 1'b1);
        test_random(RANDOM_ITEMS);

        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
